>>> src/trp_pkg.sv
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants of the touch report parser.
// ----------------------------------------------------------------------------
`default_nettype none

package trp_pkg;

    localparam int REPORT_BYTES_DEF = 28;
    localparam int QUEUE_DEPTH_DEF  = 4;

    localparam int COORD_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LIMIT  = 3'd4;

    localparam logic               RST_SWAP_XY  = 1'b1;
    localparam logic               RST_MIRROR_X = 1'b0;
    localparam logic               RST_MIRROR_Y = 1'b1;
    localparam logic [COORD_W-1:0] RST_X_LIMIT  = 12'd599;
    localparam logic [COORD_W-1:0] RST_Y_LIMIT  = 12'd449;

    // frame checking constants
    localparam logic [7:0] HOME_B0     = 8'h83;
    localparam logic [7:0] HOME_B1     = 8'h17;
    localparam logic [7:0] COUNT_FLAG  = 8'h80;
    localparam logic [7:0] MARKER      = 8'hAB;
    localparam logic [6:0] MAX_POINTS  = 7'd5;

    // request kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_FAIL = 1'b1;

    // commands from the front to the back
    typedef enum logic [1:0] {
        CMD_REJECT = 2'd0,
        CMD_REARM  = 2'd1,
        CMD_PRESS  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } trp_cmd_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] report_byte;
        logic       frame_end;
    } trp_in_t;

    typedef struct packed {
        logic               event_flag;
        logic               touch_pressed;
        logic [COORD_W-1:0] touch_x;
        logic [COORD_W-1:0] touch_y;
        logic               rearm_request;
    } trp_out_t;

endpackage

`default_nettype wire

>>> src/touch_report_parser.sv
// ----------------------------------------------------------------------------
// touch_report_parser
// Touch report frame decoder with coordinate swap, clamp and mirror.
// ----------------------------------------------------------------------------
// Takes one report byte or read-failure word per cycle whenever full is low.
// A classifier holds the frame bytes and, at frame end or on a read failure,
// posts a command to a QUEUE_DEPTH-entry queue; an event stage drains the
// queue one command per cycle, while its output is empty or being popped,
// into a single output register, so a command is held in a queue entry and
// its result in the output register. full rises only once the queue holds
// QUEUE_DEPTH commands that the output side has not drained. Configuration
// writes take effect at once and apply to commands executed afterwards.
`default_nettype none

module touch_report_parser #(
    parameter int REPORT_BYTES = trp_pkg::REPORT_BYTES_DEF,
    parameter int QUEUE_DEPTH  = trp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire trp_pkg::trp_in_t               req,
    output logic                                empty,
    input  wire logic                           pop,
    output trp_pkg::trp_out_t                   rsp,
    input  wire logic                           cfg_we,
    input  wire logic [trp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import trp_pkg::*;

    logic     accept;
    logic     cmd_push, cmd_valid, cmd_pop;
    trp_cmd_t cmd_in, cmd_out;

    assign accept = push && !full;

    trp_front #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    trp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_cmd  (cmd_in),
        .q_full  (full),
        .rd_en   (cmd_pop),
        .q_valid (cmd_valid),
        .rd_cmd  (cmd_out)
    );

    trp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

>>> src/trp_front.sv
// ----------------------------------------------------------------------------
// trp_front
// Captures report bytes and classifies each finished frame into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_front #(
    parameter int REPORT_BYTES = trp_pkg::REPORT_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire trp_pkg::trp_in_t req,
    output logic                  cmd_push,
    output trp_pkg::trp_cmd_t     cmd
);
    import trp_pkg::*;

    localparam int POS_W = $clog2(REPORT_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);
    localparam logic [POS_W-1:0] POS_B0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_B1 = POS_W'(1);
    localparam logic [POS_W-1:0] POS_B2 = POS_W'(2);
    localparam logic [POS_W-1:0] POS_B3 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_B5 = POS_W'(5);
    localparam logic [POS_W-1:0] POS_B6 = POS_W'(6);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       kept_reg [6];

    logic       last;
    logic [7:0] b6;
    logic [6:0] count;
    logic       bad_frame;

    assign last  = req.frame_end || (pos_reg == POS_LAST);
    assign b6    = (pos_reg == POS_B6) ? req.report_byte : kept_reg[5];
    assign count = kept_reg[4][6:0];

    assign bad_frame = (kept_reg[0] == HOME_B0 && kept_reg[1] == HOME_B1
                        && kept_reg[4] == COUNT_FLAG)
                    || (b6 != MARKER)
                    || (kept_reg[0] == MARKER)
                    || (kept_reg[4] == COUNT_FLAG);

    always_comb
    begin
        pos_next = pos_reg;
        cmd_push = 1'b0;
        cmd.op   = CMD_REJECT;
        cmd.px   = {kept_reg[1], kept_reg[3][7:4]};
        cmd.py   = {kept_reg[2], kept_reg[3][3:0]};
        if (accept)
        begin
            if (req.req_type == REQ_FAIL)
            begin
                pos_next = '0;
                cmd_push = 1'b1;
            end
            else if (last)
            begin
                pos_next = '0;
                cmd_push = 1'b1;
                // short frame acts as a read failure
                if (pos_reg < POS_B6 || bad_frame)
                    cmd.op = CMD_REJECT;
                else if (count == 7'd0 || count > MAX_POINTS)
                    cmd.op = CMD_REARM;
                else
                    cmd.op = CMD_PRESS;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // hold bytes 0-3, 5 and 6 of the frame in progress
    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == REQ_BYTE)
        begin
            case (pos_reg)
                POS_B0:  kept_reg[0] <= req.report_byte;
                POS_B1:  kept_reg[1] <= req.report_byte;
                POS_B2:  kept_reg[2] <= req.report_byte;
                POS_B3:  kept_reg[3] <= req.report_byte;
                POS_B5:  kept_reg[4] <= req.report_byte;
                POS_B6:  kept_reg[5] <= req.report_byte;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> src/trp_queue.sv
// ----------------------------------------------------------------------------
// trp_queue
// Short command queue between the frame classifier and the event stage.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_queue #(
    parameter int QUEUE_DEPTH = trp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire trp_pkg::trp_cmd_t wr_cmd,
    output logic                   q_full,
    input  wire logic              rd_en,
    output logic                   q_valid,
    output trp_pkg::trp_cmd_t      rd_cmd
);
    import trp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    trp_cmd_t         mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign q_full  = (cnt_reg == CNT_FULL);
    assign q_valid = (cnt_reg != '0);
    assign rd_cmd  = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("queue count above depth");
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("queue count missed a write");
`endif

endmodule

`default_nettype wire

>>> src/trp_back.sv
// ----------------------------------------------------------------------------
// trp_back
// Executes frame commands: press tracking, coordinate transform, result word.
// ----------------------------------------------------------------------------
`default_nettype none

module trp_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [trp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [trp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 cmd_valid,
    input  wire trp_pkg::trp_cmd_t                    cmd,
    output logic                                      cmd_pop,
    output logic                                      empty,
    input  wire logic                                 pop,
    output trp_pkg::trp_out_t                         rsp
);
    import trp_pkg::*;

    logic               swap_xy_reg, mirror_x_reg, mirror_y_reg;
    logic [COORD_W-1:0] x_limit_reg, y_limit_reg;

    logic     was_pressed_reg, was_pressed_next;
    logic     out_valid_reg, out_valid_next;
    trp_out_t out_reg, out_next;

    logic               produce;
    logic [COORD_W-1:0] tx, ty;

    function automatic logic [COORD_W-1:0] clamp_mirror(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W-1:0] lim,
        input logic               mir
    );
        logic [COORD_W-1:0] c;
        begin
            c = v;
            if (lim != '0)
            begin
                if (c > lim)
                    c = lim;
                if (mir)
                    c = lim - c;
            end
            return c;
        end
    endfunction

    assign tx = clamp_mirror(swap_xy_reg ? cmd.py : cmd.px, x_limit_reg, mirror_x_reg);
    assign ty = clamp_mirror(swap_xy_reg ? cmd.px : cmd.py, y_limit_reg, mirror_y_reg);

    // advance when the output slot is free or being drained
    assign cmd_pop = cmd_valid && (!out_valid_reg || pop);
    assign empty   = !out_valid_reg;
    assign rsp     = out_reg;

    always_comb
    begin
        was_pressed_next = was_pressed_reg;
        out_next         = out_reg;
        produce          = 1'b0;
        out_valid_next   = out_valid_reg && !pop;
        if (cmd_pop)
        begin
            out_next = '0;
            case (cmd.op)
                CMD_PRESS:
                begin
                    produce                = 1'b1;
                    was_pressed_next       = 1'b1;
                    out_next.event_flag    = 1'b1;
                    out_next.touch_pressed = 1'b1;
                    out_next.touch_x       = tx;
                    out_next.touch_y       = ty;
                end
                CMD_REARM:
                begin
                    produce                = 1'b1;
                    was_pressed_next       = 1'b0;
                    out_next.event_flag    = was_pressed_reg;
                    out_next.rearm_request = 1'b1;
                end
                default:
                begin
                    // release only when the pad was down
                    produce             = was_pressed_reg;
                    was_pressed_next    = 1'b0;
                    out_next.event_flag = was_pressed_reg;
                end
            endcase
            if (produce)
                out_valid_next = 1'b1;
            else
                out_next = out_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_pressed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            was_pressed_reg <= was_pressed_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_xy_reg  <= RST_SWAP_XY;
            mirror_x_reg <= RST_MIRROR_X;
            mirror_y_reg <= RST_MIRROR_Y;
            x_limit_reg  <= RST_X_LIMIT;
            y_limit_reg  <= RST_Y_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SWAP_XY:  swap_xy_reg  <= cfg_data[0];
                REG_MIRROR_X: mirror_x_reg <= cfg_data[0];
                REG_MIRROR_Y: mirror_y_reg <= cfg_data[0];
                REG_X_LIMIT:  x_limit_reg  <= cfg_data;
                REG_Y_LIMIT:  y_limit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_press_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.touch_pressed) |-> out_reg.event_flag)
        else $error("press reported without event flag");
    a_release_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.touch_pressed)
            |-> (out_reg.touch_x == '0 && out_reg.touch_y == '0))
        else $error("non-press result carries coordinates");
    a_press_state: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.op == CMD_PRESS) |=> was_pressed_reg)
        else $error("press not recorded");
    a_rearm_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.rearm_request) |-> !out_reg.touch_pressed)
        else $error("rearm request on a press");
`endif

endmodule

`default_nettype wire
